// ===== rtl/core/urmrf_pkg.sv =====
// urmrf_pkg: shared types and constants of the uart register block with receive fifo
// request kinds, register word map, flag and interrupt bits, reset values, id tables
// no dependencies
`default_nettype none

package urmrf_pkg;

    // kind of one input beat
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_RX    = 2'd2,
        REQ_BREAK = 2'd3
    } req_t;

    // register word indexes (byte offset >> 2)
    localparam logic [9:0] W_DATA   = 10'd0;
    localparam logic [9:0] W_RSR    = 10'd1;
    localparam logic [9:0] W_FLAG   = 10'd6;
    localparam logic [9:0] W_ILPR   = 10'd8;
    localparam logic [9:0] W_IBRD   = 10'd9;
    localparam logic [9:0] W_FBRD   = 10'd10;
    localparam logic [9:0] W_LCR    = 10'd11;
    localparam logic [9:0] W_CR     = 10'd12;
    localparam logic [9:0] W_IFLS   = 10'd13;
    localparam logic [9:0] W_IMSC   = 10'd14;
    localparam logic [9:0] W_RIS    = 10'd15;
    localparam logic [9:0] W_MIS    = 10'd16;
    localparam logic [9:0] W_ICR    = 10'd17;
    localparam logic [9:0] W_DMACR  = 10'd18;

    // first byte offset of the read-only id bytes
    localparam logic [11:0] ID_BASE = 12'hfe0;

    // bits and special values
    localparam logic [31:0] INT_RX      = 32'h10;
    localparam logic [31:0] INT_TX      = 32'h20;
    localparam logic [7:0]  FLAG_RXFF   = 8'h40;
    localparam logic [7:0]  FLAG_RXFE   = 8'h10;
    localparam logic [10:0] BREAK_ENTRY = 11'h400;
    localparam int          LCR_FEN_BIT = 4;

    // reset values
    localparam logic [7:0]  FLAG_RESET = 8'h90;
    localparam logic [31:0] CR_RESET   = 32'h300;
    localparam logic [31:0] IFLS_RESET = 32'h12;

    // fifo request from the register logic
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [10:0] data;
    } fifo_ctrl_t;

    // peripheral id byte, standard or alternate table
    function automatic logic [7:0] id_byte(input logic variant, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (variant) begin
            unique case (idx)
                3'd0: b = 8'h11;
                3'd1: b = 8'h00;
                3'd2: b = 8'h18;
                3'd3: b = 8'h01;
                3'd4: b = 8'h0d;
                3'd5: b = 8'hf0;
                3'd6: b = 8'h05;
                3'd7: b = 8'hb1;
                default: b = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0: b = 8'h11;
                3'd1: b = 8'h10;
                3'd2: b = 8'h14;
                3'd3: b = 8'h00;
                3'd4: b = 8'h0d;
                3'd5: b = 8'hf0;
                3'd6: b = 8'h05;
                3'd7: b = 8'hb1;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/urmrf_rx_fifo.sv =====
// urmrf_rx_fifo: receive fifo storage with head and count pointers
// entry at the head is read from a registered memory port, with a write bypass
// depends on urmrf_pkg
`default_nettype none

module urmrf_rx_fifo #(
    parameter int RX_DEPTH = 16,
    localparam int AW = $clog2(RX_DEPTH),
    localparam int CW = $clog2(RX_DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire urmrf_pkg::fifo_ctrl_t ctrl,
    output logic [CW-1:0]              count,
    output logic [10:0]                head_data
);
    import urmrf_pkg::*;

    localparam int SW = AW + 1;

    logic [10:0]       mem [RX_DEPTH];
    logic [RX_DEPTH-1:0] valid_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [SW-1:0]     slot_sum;
    logic [SW-1:0]     slot_wrap;
    logic [AW-1:0]     slot;
    logic              pop_ok;
    logic [10:0]       mem_q_reg;
    logic [10:0]       byp_data_reg;
    logic              hd_byp_reg;
    logic              hd_val_reg;

    // tail slot, head plus count folded once into range
    assign slot_sum  = SW'(head_reg) + SW'(count_reg);
    assign slot_wrap = (slot_sum >= SW'(RX_DEPTH)) ? (slot_sum - SW'(RX_DEPTH)) : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    // pointer update
    assign pop_ok = ctrl.pop && (count_reg != '0);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop_ok) begin
            head_next  = (head_reg == AW'(RX_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end else if (ctrl.push) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            valid_reg  <= '0;
            hd_byp_reg <= 1'b0;
            hd_val_reg <= 1'b0;
        end else begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            if (ctrl.push) begin
                valid_reg[slot] <= 1'b1;
            end
            hd_byp_reg <= ctrl.push && (slot == head_next);
            hd_val_reg <= valid_reg[head_next];
        end
    end

    // storage: one write port at the tail, one registered read at the next head
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[slot] <= ctrl.data;
        end
        mem_q_reg    <= mem[head_next];
        byp_data_reg <= ctrl.data;
    end

    // never-written entries read as zero
    assign head_data = hd_byp_reg ? byp_data_reg : (hd_val_reg ? mem_q_reg : '0);
    assign count     = count_reg;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(RX_DEPTH))
        else $error("rx fifo count beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> (count_reg != CW'(RX_DEPTH)))
        else $error("push into full rx fifo");

    a_empty_pop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.pop && count_reg == '0) |=> $stable(head_reg))
        else $error("head moved on pop of empty fifo");

    a_push_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.push && count_reg == '0) |=> (head_data == $past(ctrl.data)))
        else $error("head entry wrong after push into empty fifo");

endmodule

`default_nettype wire

// ===== rtl/core/uart_register_model_rx_fifo.sv =====
// UART register block with a receive FIFO. Each input beat is a bus read, a bus
// write, a received character or a line break; each gives exactly one result beat.
// An input beat is captured in an input register, worked on by one level of register
// and FIFO logic, and its result is held in an output register, so one beat per cycle
// is taken as long as results are consumed.
// Received characters are dropped when rx_ready (from the previous result) was low.
// The id_variant register may only be written while no beat is in flight.
// uart_register_model_rx_fifo: top level; depends on urmrf_pkg and urmrf_rx_fifo
`default_nettype none

module uart_register_model_rx_fifo #(
    parameter int RX_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,      // id_variant
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,       // byte_offset[11:0], write_data[43:12], rx_byte[51:44]
    input  wire logic [1:0]  s_tuser,       // req_type[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata        // read_data[31:0], irq[32], tx_valid[33],
                                            // tx_byte[41:34], rx_ready[42], bus_error[43]
);
    import urmrf_pkg::*;

    localparam int CW = $clog2(RX_DEPTH + 1);

    // input register
    logic        a_valid_reg;
    req_t        a_req_reg;
    logic [11:0] a_off_reg;
    logic [31:0] a_wdata_reg;
    logic [7:0]  a_rxb_reg;

    // output register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [47:0] out_data_next;

    // block state
    logic        id_variant_reg;
    logic [7:0]  flag_reg,       flag_next;
    logic [31:0] line_ctrl_reg,  line_ctrl_next;
    logic [31:0] ctrl_reg,       ctrl_next;
    logic [31:0] dma_ctrl_reg,   dma_ctrl_next;
    logic [31:0] irq_mask_reg,   irq_mask_next;
    logic [31:0] irq_raw_reg,    irq_raw_next;
    logic [31:0] irda_lp_reg,    irda_lp_next;
    logic [31:0] baud_int_reg,   baud_int_next;
    logic [31:0] baud_frac_reg,  baud_frac_next;
    logic [31:0] fifo_lvl_reg,   fifo_lvl_next;

    logic        advance;
    logic        a_fire;
    fifo_ctrl_t  fifo_ctrl;
    logic [CW-1:0] fifo_count;
    logic [10:0] fifo_head;

    logic [9:0]  word;
    logic        is_id;
    logic        fifo_en;
    logic        can_acc;
    logic        push;
    logic        pop;
    logic [CW-1:0] cnt_after;
    logic [31:0] rd;
    logic        err;
    logic        txv;
    logic [7:0]  txb;
    logic        rx_rdy;
    logic        irq;

    // handshakes
    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign a_fire    = a_valid_reg && advance;
    assign s_tready  = !a_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_req_reg   <= req_t'(s_tuser);
            a_off_reg   <= s_tdata[11:0];
            a_wdata_reg <= s_tdata[43:12];
            a_rxb_reg   <= s_tdata[51:44];
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_variant_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            id_variant_reg <= cfg_data;
        end
    end

    // decode
    assign word    = a_off_reg[11:2];
    assign is_id   = (a_off_reg >= ID_BASE);
    assign fifo_en = line_ctrl_reg[LCR_FEN_BIT];
    assign can_acc = fifo_en ? (fifo_count < CW'(RX_DEPTH)) : (fifo_count == '0);

    // register access and fifo effects of one beat
    always_comb begin
        rd             = '0;
        err            = 1'b0;
        txv            = 1'b0;
        txb            = '0;
        push           = 1'b0;
        pop            = 1'b0;
        flag_next      = flag_reg;
        line_ctrl_next = line_ctrl_reg;
        ctrl_next      = ctrl_reg;
        dma_ctrl_next  = dma_ctrl_reg;
        irq_mask_next  = irq_mask_reg;
        irq_raw_next   = irq_raw_reg;
        irda_lp_next   = irda_lp_reg;
        baud_int_next  = baud_int_reg;
        baud_frac_next = baud_frac_reg;
        fifo_lvl_next  = fifo_lvl_reg;

        unique case (a_req_reg)
            REQ_READ: begin
                if (is_id) begin
                    rd = {24'b0, id_byte(id_variant_reg, a_off_reg[4:2])};
                end else begin
                    unique case (word)
                        W_DATA: begin
                            pop = 1'b1;
                            rd  = {21'b0, fifo_head};
                        end
                        W_RSR:   rd = '0;
                        W_FLAG:  rd = {24'b0, flag_reg};
                        W_ILPR:  rd = irda_lp_reg;
                        W_IBRD:  rd = baud_int_reg;
                        W_FBRD:  rd = baud_frac_reg;
                        W_LCR:   rd = line_ctrl_reg;
                        W_CR:    rd = ctrl_reg;
                        W_IFLS:  rd = fifo_lvl_reg;
                        W_IMSC:  rd = irq_mask_reg;
                        W_RIS:   rd = irq_raw_reg;
                        W_MIS:   rd = irq_raw_reg & irq_mask_reg;
                        W_DMACR: rd = dma_ctrl_reg;
                        default: err = 1'b1;
                    endcase
                end
            end
            REQ_WRITE: begin
                unique case (word)
                    W_DATA: begin
                        txv          = 1'b1;
                        txb          = a_wdata_reg[7:0];
                        irq_raw_next = irq_raw_reg | INT_TX;
                    end
                    W_RSR:   ;
                    W_FLAG:  ;
                    W_ILPR:  irda_lp_next   = a_wdata_reg;
                    W_IBRD:  baud_int_next  = a_wdata_reg;
                    W_FBRD:  baud_frac_next = a_wdata_reg;
                    W_LCR:   line_ctrl_next = a_wdata_reg;
                    W_CR:    ctrl_next      = a_wdata_reg;
                    W_IFLS:  fifo_lvl_next  = a_wdata_reg;
                    W_IMSC:  irq_mask_next  = a_wdata_reg;
                    W_ICR:   irq_raw_next   = irq_raw_reg & ~a_wdata_reg;
                    W_DMACR: begin
                        dma_ctrl_next = a_wdata_reg;
                        err           = |a_wdata_reg[1:0];
                    end
                    default: err = 1'b1;
                endcase
            end
            REQ_RX:    push = can_acc;
            REQ_BREAK: push = can_acc;
            default:   push = 1'b0;
        endcase

        // fill level after this beat
        if (pop && fifo_count != '0) begin
            cnt_after = fifo_count - 1'b1;
        end else if (push) begin
            cnt_after = fifo_count + 1'b1;
        end else begin
            cnt_after = fifo_count;
        end

        // data read: full flag off, empty flag and rx interrupt follow the level
        if (pop) begin
            flag_next = flag_next & ~FLAG_RXFF;
            if (cnt_after == '0) begin
                flag_next    = flag_next | FLAG_RXFE;
                irq_raw_next = irq_raw_next & ~INT_RX;
            end
        end

        // push: empty flag off, full flag when at depth or fifo off
        if (push) begin
            flag_next = flag_next & ~FLAG_RXFE;
            if (!fifo_en || cnt_after == CW'(RX_DEPTH)) begin
                flag_next = flag_next | FLAG_RXFF;
            end
            if (cnt_after == CW'(1)) begin
                irq_raw_next = irq_raw_next | INT_RX;
            end
        end

        rx_rdy = line_ctrl_next[LCR_FEN_BIT] ? (cnt_after < CW'(RX_DEPTH))
                                             : (cnt_after == '0);
        irq    = |(irq_raw_next & irq_mask_next);

        out_data_next = {4'b0, err, rx_rdy, txb, txv, irq, rd};
    end

    // fifo request
    assign fifo_ctrl.push = a_fire && push;
    assign fifo_ctrl.pop  = a_fire && pop;
    assign fifo_ctrl.data = (a_req_reg == REQ_BREAK) ? BREAK_ENTRY : {3'b0, a_rxb_reg};

    urmrf_rx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fifo_ctrl),
        .count     (fifo_count),
        .head_data (fifo_head)
    );

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg      <= FLAG_RESET;
            line_ctrl_reg <= '0;
            ctrl_reg      <= CR_RESET;
            dma_ctrl_reg  <= '0;
            irq_mask_reg  <= '0;
            irq_raw_reg   <= '0;
            irda_lp_reg   <= '0;
            baud_int_reg  <= '0;
            baud_frac_reg <= '0;
            fifo_lvl_reg  <= IFLS_RESET;
        end else if (a_fire) begin
            flag_reg      <= flag_next;
            line_ctrl_reg <= line_ctrl_next;
            ctrl_reg      <= ctrl_next;
            dma_ctrl_reg  <= dma_ctrl_next;
            irq_mask_reg  <= irq_mask_next;
            irq_raw_reg   <= irq_raw_next;
            irda_lp_reg   <= irda_lp_next;
            baud_int_reg  <= baud_int_next;
            baud_frac_reg <= baud_frac_next;
            fifo_lvl_reg  <= fifo_lvl_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // checks
    a_tx_sets_int: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && a_req_reg == REQ_WRITE && word == W_DATA)
            |=> ((|(irq_raw_reg & INT_TX)) && m_tdata[33]))
        else $error("data write did not raise tx interrupt");

    a_rx_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && (a_req_reg == REQ_RX || a_req_reg == REQ_BREAK)) |=> !m_tdata[43])
        else $error("bus error on received item");

    a_empty_clears_rx_int: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && pop && fifo_count <= CW'(1))
            |=> (!(|(irq_raw_reg & INT_RX)) && (|(flag_reg & FLAG_RXFE))))
        else $error("rx interrupt or empty flag wrong after draining read");

endmodule

`default_nettype wire

// ===== dv/tb_uart_register_model_rx_fifo.sv =====
// tb_uart_register_model_rx_fifo: self-checking bench for the uart register block
// a scoreboard class predicts every result beat; tasks drive the input and config channels
// depends on urmrf_pkg and uart_register_model_rx_fifo
`default_nettype none

module tb_uart_register_model_rx_fifo;
    import urmrf_pkg::*;

    localparam int RX_DEPTH     = 16;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 120;

    // one request beat, fields as carried on the input stream
    typedef struct packed {
        req_t        kind;
        logic [11:0] offset;
        logic [31:0] wdata;
        logic [7:0]  rx_char;
    } uart_req_t;

    // one result beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_ready;
        logic        bus_error;
    } uart_rsp_t;

    // traffic mixes used by the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } mix_t;

    // register block predictor with its queue of expected results
    class uart_reg_scoreboard;
        logic [7:0]  id_rom [2][8] = '{
            '{8'h11, 8'h10, 8'h14, 8'h00, 8'h0d, 8'hf0, 8'h05, 8'hb1},
            '{8'h11, 8'h00, 8'h18, 8'h01, 8'h0d, 8'hf0, 8'h05, 8'hb1}
        };
        logic        variant;
        logic [10:0] fifo_mem [RX_DEPTH];
        int unsigned head;
        int unsigned count;
        logic [7:0]  flags;
        logic [31:0] line_ctrl, ctrl, dma_ctrl, irq_mask, irq_raw;
        logic [31:0] irda_lp, baud_int, baud_frac, fifo_level;
        uart_rsp_t   pending_results [$];
        int          mismatches;

        function new();
            variant = 1'b0;
            foreach (fifo_mem[i]) fifo_mem[i] = '0;
            head = 0;
            count = 0;
            flags = FLAG_RESET;
            line_ctrl = '0;
            ctrl = CR_RESET;
            dma_ctrl = '0;
            irq_mask = '0;
            irq_raw = '0;
            irda_lp = '0;
            baud_int = '0;
            baud_frac = '0;
            fifo_level = IFLS_RESET;
            mismatches = 0;
        endfunction

        function void set_variant(logic v);
            variant = v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // room for one more received entry
        function bit room_left();
            if (line_ctrl[LCR_FEN_BIT])
                return count < RX_DEPTH;
            return count < 1;
        endfunction

        function void store_rx_entry(logic [10:0] v);
            if (!room_left())
                return;
            fifo_mem[(head + count) % RX_DEPTH] = v;
            count++;
            flags &= ~FLAG_RXFE;
            if (!line_ctrl[LCR_FEN_BIT] || count == RX_DEPTH)
                flags |= FLAG_RXFF;
            if (count == 1)
                irq_raw |= INT_RX;
        endfunction

        // work out the result of one accepted request
        function void apply_request(uart_req_t r);
            uart_rsp_t  e;
            logic [9:0] word;
            e = '0;
            word = r.offset[11:2];
            case (r.kind)
                REQ_READ: begin
                    if (r.offset >= ID_BASE) begin
                        e.read_data = {24'd0, id_rom[variant][r.offset[4:2]]};
                    end else begin
                        case (word)
                            W_DATA: begin
                                flags &= ~FLAG_RXFF;
                                e.read_data = {21'd0, fifo_mem[head]};
                                if (count > 0) begin
                                    count--;
                                    head = (head + 1) % RX_DEPTH;
                                end
                                if (count == 0) begin
                                    flags |= FLAG_RXFE;
                                    irq_raw &= ~INT_RX;
                                end
                            end
                            W_RSR:   e.read_data = '0;
                            W_FLAG:  e.read_data = {24'd0, flags};
                            W_ILPR:  e.read_data = irda_lp;
                            W_IBRD:  e.read_data = baud_int;
                            W_FBRD:  e.read_data = baud_frac;
                            W_LCR:   e.read_data = line_ctrl;
                            W_CR:    e.read_data = ctrl;
                            W_IFLS:  e.read_data = fifo_level;
                            W_IMSC:  e.read_data = irq_mask;
                            W_RIS:   e.read_data = irq_raw;
                            W_MIS:   e.read_data = irq_raw & irq_mask;
                            W_DMACR: e.read_data = dma_ctrl;
                            default: e.bus_error = 1'b1;
                        endcase
                    end
                end
                REQ_WRITE: begin
                    case (word)
                        W_DATA: begin
                            e.tx_valid = 1'b1;
                            e.tx_byte = r.wdata[7:0];
                            irq_raw |= INT_TX;
                        end
                        W_RSR, W_FLAG: ;
                        W_ILPR:  irda_lp = r.wdata;
                        W_IBRD:  baud_int = r.wdata;
                        W_FBRD:  baud_frac = r.wdata;
                        W_LCR:   line_ctrl = r.wdata;
                        W_CR:    ctrl = r.wdata;
                        W_IFLS:  fifo_level = r.wdata;
                        W_IMSC:  irq_mask = r.wdata;
                        W_ICR:   irq_raw &= ~r.wdata;
                        W_DMACR: begin
                            dma_ctrl = r.wdata;
                            e.bus_error = |r.wdata[1:0];
                        end
                        default: e.bus_error = 1'b1;
                    endcase
                end
                REQ_RX:    store_rx_entry({3'd0, r.rx_char});
                REQ_BREAK: store_rx_entry(BREAK_ENTRY);
                default: ;
            endcase
            e.irq = |(irq_raw & irq_mask);
            e.rx_ready = room_left();
            pending_results.push_back(e);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [47:0] beat);
            uart_rsp_t got, exp;
            got.read_data = beat[31:0];
            got.irq = beat[32];
            got.tx_valid = beat[33];
            got.tx_byte = beat[41:34];
            got.rx_ready = beat[42];
            got.bus_error = beat[43];
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: %h", beat);
                mismatches++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.read_data !== exp.read_data) begin
                $error("read_data: expected %h, got %h", exp.read_data, got.read_data);
                mismatches++;
            end
            if (got.irq !== exp.irq) begin
                $error("irq: expected %b, got %b", exp.irq, got.irq);
                mismatches++;
            end
            if (got.tx_valid !== exp.tx_valid) begin
                $error("tx_valid: expected %b, got %b", exp.tx_valid, got.tx_valid);
                mismatches++;
            end
            if (got.tx_byte !== exp.tx_byte) begin
                $error("tx_byte: expected %h, got %h", exp.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.rx_ready !== exp.rx_ready) begin
                $error("rx_ready: expected %b, got %b", exp.rx_ready, got.rx_ready);
                mismatches++;
            end
            if (got.bus_error !== exp.bus_error) begin
                $error("bus_error: expected %b, got %b", exp.bus_error, got.bus_error);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;       // byte_offset[11:0], write_data[43:12], rx_byte[51:44]
    logic [1:0]  s_tuser;       // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;       // read_data[31:0], irq[32], tx_valid[33], tx_byte[41:34],
                                // rx_ready[42], bus_error[43]

    uart_reg_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit held = 1'b0;

    logic [9:0] reg_words [14] = '{W_DATA, W_RSR, W_FLAG, W_ILPR, W_IBRD, W_FBRD, W_LCR,
                                   W_CR, W_IFLS, W_IMSC, W_RIS, W_MIS, W_ICR, W_DMACR};

    uart_register_model_rx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // monitor: note accepted beats on every channel at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_variant(cfg_data);
            if (s_tvalid && s_tready)
                sb.apply_request(uart_req_t'({s_tuser, s_tdata[11:0], s_tdata[43:12],
                                              s_tdata[51:44]}));
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
                results_seen++;
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off to fill the block
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && !held && results_seen >= 150) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held = 1'b1;
            end
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic uart_req_t make_req(req_t k, logic [11:0] off, logic [31:0] wd,
                                           logic [7:0] rb);
        uart_req_t r;
        r.kind = k;
        r.offset = off;
        r.wdata = wd;
        r.rx_char = rb;
        return r;
    endfunction

    // random request, weighted towards filling or draining the receive fifo
    function automatic uart_req_t random_item(mix_t mode);
        uart_req_t r;
        int roll;
        int pick;
        r.offset = 12'($urandom_range(4095));
        r.wdata = $urandom();
        r.rx_char = 8'($urandom_range(255));
        roll = $urandom_range(99);
        case (mode)
            MIX_FILL:  r.kind = req_t'(roll < 55 ? REQ_RX : roll < 65 ? REQ_BREAK :
                                       roll < 85 ? REQ_READ : REQ_WRITE);
            MIX_DRAIN: r.kind = req_t'(roll < 15 ? REQ_RX : roll < 20 ? REQ_BREAK :
                                       roll < 85 ? REQ_READ : REQ_WRITE);
            default:   r.kind = req_t'(roll < 25 ? REQ_RX : roll < 50 ? REQ_BREAK :
                                       roll < 75 ? REQ_READ : REQ_WRITE);
        endcase
        pick = $urandom_range(99);
        if (pick < 80) begin
            if (r.kind == REQ_READ && pick < (mode == MIX_DRAIN ? 70 : 35))
                r.offset = {W_DATA, r.offset[1:0]};
            else
                r.offset = {reg_words[$urandom_range(13)], r.offset[1:0]};
        end else if (pick < 90) begin
            r.offset = ID_BASE + 12'($urandom_range(31));
        end
        // keep the fifo enabled most of the time
        if (r.kind == REQ_WRITE && r.offset[11:2] == W_LCR)
            r.wdata[LCR_FEN_BIT] = ($urandom_range(99) < 80);
        return r;
    endfunction

    // offer one beat, with random idle cycles ahead of it
    task automatic send_item(input uart_req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.kind;
        s_tdata <= {4'd0, r.rx_char, r.wdata, r.offset};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_variant(input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        uart_req_t directed [$];
        mix_t      mode;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_READ;
        mode = MIX_ANY;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // short directed part: id bytes, empty fifo, fifo off and on, breaks, bad offsets
        directed.push_back(make_req(REQ_READ,  12'hfe0, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'hfff, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'h000, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'h018, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'h030, '0, '0));
        directed.push_back(make_req(REQ_RX,    12'h000, '0, 8'h00));
        directed.push_back(make_req(REQ_RX,    12'hfff, '1, 8'hff));
        directed.push_back(make_req(REQ_WRITE, 12'h038, 32'hffff_ffff, '0));
        directed.push_back(make_req(REQ_READ,  12'h040, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'h000, '0, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h02c, 32'h10, '0));
        directed.push_back(make_req(REQ_BREAK, 12'h000, '0, '0));
        directed.push_back(make_req(REQ_RX,    12'h000, '0, 8'hff));
        directed.push_back(make_req(REQ_READ,  12'h000, '0, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h000, 32'hffff_ffa5, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h044, 32'hffff_ffff, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h048, 32'h3, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h048, 32'h4, '0));
        directed.push_back(make_req(REQ_READ,  12'h044, '0, '0));
        directed.push_back(make_req(REQ_WRITE, 12'hfe0, 32'h0, '0));
        directed.push_back(make_req(REQ_READ,  12'h02f, '0, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h004, 32'hffff_ffff, '0));
        directed.push_back(make_req(REQ_WRITE, 12'h018, 32'h0, '0));
        directed.push_back(make_req(REQ_READ,  12'h3fc, '0, '0));
        directed.push_back(make_req(REQ_READ,  12'h034, '0, '0));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // id table selection changes only with nothing in flight
            if (ph > 0)
                settle();
            write_variant(ph == 1);
            if (ph == 0)
                foreach (directed[i]) send_item(directed[i]);
            for (int n = 0; n < 630; n++) begin
                if (n % 24 == 0)
                    mode = mix_t'($urandom_range(2));
                if (ph == 2 && n == 300)
                    settle();
                send_item(random_item(mode));
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/urmrf_pkg.sv
rtl/core/urmrf_rx_fifo.sv
rtl/core/uart_register_model_rx_fifo.sv
dv/tb_uart_register_model_rx_fifo.sv
